>>> sv/msm_pkg.sv
// Shared constants for the markup-stripping substring matcher.
package msm_pkg;

    // Query storage and configuration widths
    localparam int QUERY_WORD_W          = 64;
    localparam int QUERY_WORD_CHARS      = QUERY_WORD_W / 8;
    localparam int QUERY_STORED_CHARS    = 2 * QUERY_WORD_CHARS;
    localparam int QUERY_LEN_W           = 5;
    localparam int CFG_INDEX_W           = 2;
    localparam int CFG_DATA_W            = QUERY_WORD_W;
    localparam int MAX_QUERY_CHARS_DFLT  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_LEN  = 2'd2;

    // Character codes
    localparam logic [7:0] CHAR_TAG_OPEN  = 8'h3C;   // '<'
    localparam logic [7:0] CHAR_TAG_CLOSE = 8'h3E;   // '>'
    localparam logic [7:0] CHAR_SPACE     = 8'h20;   // ' '
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;   // 'A'
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;   // 'Z'
    localparam logic [7:0] CASE_FOLD_OFS  = 8'h20;   // 'a' - 'A'

    typedef logic [7:0] char_t;

endpackage

>>> sv/markup_stripping_substring_matcher_core.sv
// Streaming tag stripper with a sliding-window substring match and sticky found flag.
//
// One byte transfers per clock unless stalled; its result (found, verdict_final) is
// presented on the output register in the cycle after the transfer. The per-byte
// path is the window shift plus a parallel compare of all MAX_QUERY_CHARS window
// characters against the query, feeding the sticky match flag. Input stall follows
// the output register only: a byte is taken whenever the output is empty or is
// being taken in the same cycle. A byte marked document_end closes the document
// and clears tag mode, the window fill and the flag; query registers keep their
// values. Query length zero, or above MAX_QUERY_CHARS, never matches.
module markup_stripping_substring_matcher_core
    import msm_pkg::*;
#(
    parameter int MAX_QUERY_CHARS = MAX_QUERY_CHARS_DFLT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   document_end,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic                   verdict_final
);

    localparam int CNT_W = $clog2(MAX_QUERY_CHARS + 1);
    localparam int CMP_W = (CNT_W > QUERY_LEN_W) ? CNT_W : QUERY_LEN_W;

    // Configuration registers
    logic [QUERY_WORD_W-1:0] query_low_reg;
    logic [QUERY_WORD_W-1:0] query_high_reg;
    logic [QUERY_LEN_W-1:0]  query_len_reg;

    // Document state
    char_t               recent_reg [MAX_QUERY_CHARS];
    char_t               recent_next[MAX_QUERY_CHARS];
    logic [CNT_W-1:0]    chars_seen_reg;
    logic [CNT_W-1:0]    chars_seen_next;
    logic                inside_tag_reg;
    logic                inside_tag_next;
    logic                match_seen_reg;
    logic                match_seen_next;

    // Output register
    logic                out_valid_reg;
    logic                found_reg;
    logic                verdict_final_reg;

    // Per-byte decode
    logic                in_xfer;
    logic                is_open;
    logic                is_close;
    logic                do_append;
    char_t               append_char;
    char_t               query_bytes[QUERY_STORED_CHARS];
    logic [MAX_QUERY_CHARS-1:0] lane_ok;
    logic                len_ok;
    logic                window_hit;

    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_low_reg  <= '0;
            query_high_reg <= '0;
            query_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                CFG_QUERY_LOW:  query_low_reg  <= cfg_data;
                CFG_QUERY_HIGH: query_high_reg <= cfg_data;
                CFG_QUERY_LEN:  query_len_reg  <= cfg_data[QUERY_LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Query bytes, character 0 in the lowest byte of the low word
    always_comb
    begin
        for (int k = 0; k < QUERY_WORD_CHARS; k++)
        begin
            query_bytes[k]                    = query_low_reg[8*k +: 8];
            query_bytes[k + QUERY_WORD_CHARS] = query_high_reg[8*k +: 8];
        end
    end

    // Classify the byte and fold upper case
    always_comb
    begin
        is_open  = (data_byte == CHAR_TAG_OPEN);
        is_close = (data_byte == CHAR_TAG_CLOSE);
        if (is_close)
        begin
            append_char = CHAR_SPACE;
        end
        else if (data_byte >= CHAR_UPPER_A && data_byte <= CHAR_UPPER_Z)
        begin
            append_char = data_byte + CASE_FOLD_OFS;
        end
        else
        begin
            append_char = data_byte;
        end
        do_append = is_close | (~is_open & ~inside_tag_reg);
    end

    // Shifted window and fill count
    always_comb
    begin
        recent_next[0] = append_char;
        for (int i = 1; i < MAX_QUERY_CHARS; i++)
        begin
            recent_next[i] = recent_reg[i-1];
        end
        if (do_append && (chars_seen_reg != CNT_W'(MAX_QUERY_CHARS)))
        begin
            chars_seen_next = chars_seen_reg + 1'b1;
        end
        else
        begin
            chars_seen_next = chars_seen_reg;
        end
    end

    // Parallel compare: window entry i against query character len-1-i
    always_comb
    begin
        int    qi;
        char_t qc;
        for (int i = 0; i < MAX_QUERY_CHARS; i++)
        begin
            qi = 0;
            qc = '0;
            if (int'(query_len_reg) > i)
            begin
                qi = int'(query_len_reg) - 1 - i;
                if (qi < QUERY_STORED_CHARS)
                begin
                    qc = query_bytes[qi[$clog2(QUERY_STORED_CHARS)-1:0]];
                end
                lane_ok[i] = (recent_next[i] == qc);
            end
            else
            begin
                lane_ok[i] = 1'b1;
            end
        end
        len_ok = (query_len_reg != '0)
               && (CMP_W'(query_len_reg) <= CMP_W'(MAX_QUERY_CHARS))
               && (CMP_W'(chars_seen_next) >= CMP_W'(query_len_reg));
        window_hit = do_append & len_ok & (&lane_ok);
    end

    // Next tag mode and sticky flag
    always_comb
    begin
        priority if (is_open)
        begin
            inside_tag_next = 1'b1;
        end
        else if (is_close)
        begin
            inside_tag_next = 1'b0;
        end
        else
        begin
            inside_tag_next = inside_tag_reg;
        end
        match_seen_next = match_seen_reg | window_hit;
    end

    // Document state update; document end clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_seen_reg <= '0;
            inside_tag_reg <= 1'b0;
            match_seen_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (document_end)
            begin
                chars_seen_reg <= '0;
                inside_tag_reg <= 1'b0;
                match_seen_reg <= 1'b0;
            end
            else
            begin
                chars_seen_reg <= chars_seen_next;
                inside_tag_reg <= inside_tag_next;
                match_seen_reg <= match_seen_next;
            end
        end
    end

    // Window storage; entries past the fill count are never compared
    always_ff @(posedge clk)
    begin
        if (in_xfer && do_append)
        begin
            for (int i = 0; i < MAX_QUERY_CHARS; i++)
            begin
                recent_reg[i] <= recent_next[i];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            found_reg         <= match_seen_next;
            verdict_final_reg <= document_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign verdict_final = verdict_final_reg;

    // Assertions
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        chars_seen_reg <= CNT_W'(MAX_QUERY_CHARS))
        else $error("window fill count exceeds window depth");

    a_xfer_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid_reg)
        else $error("transferred byte produced no result");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && document_end) |=>
            (verdict_final_reg && chars_seen_reg == '0 && !inside_tag_reg
             && !match_seen_reg))
        else $error("document end did not close the document");

    a_open_enters_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !document_end && data_byte == CHAR_TAG_OPEN) |=>
            (inside_tag_reg && $stable(chars_seen_reg)))
        else $error("tag open byte mishandled");

    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !document_end && match_seen_reg) |=> (match_seen_reg && found_reg))
        else $error("found flag dropped within a document");

endmodule

>>> tb/tb_markup_stripping_substring_matcher_core.sv
// Self-checking bench for the tag-stripping substring matcher: directed and random documents.
module tb_markup_stripping_substring_matcher_core
    import msm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   WINDOW_CHARS = MAX_QUERY_CHARS_DFLT;
    localparam int   ITEM_TARGET  = 1650;
    localparam int   STALL_LIMIT  = 1000;
    localparam int   PRINT_LIMIT  = 40;
    localparam char_t LOWER_A     = CHAR_UPPER_A + CASE_FOLD_OFS;
    localparam char_t LOWER_Z     = CHAR_UPPER_Z + CASE_FOLD_OFS;

    typedef struct packed {
        logic hit;
        logic closing;
    } verdict_t;

    // Predicts the found flag per byte and holds the verdicts still owed by the block
    class verdict_scoreboard;
        verdict_t    verdicts[$];
        logic [63:0] query_low;
        logic [63:0] query_high;
        logic [4:0]  query_len;
        char_t       text_window[WINDOW_CHARS];
        int unsigned window_fill;
        bit          in_tag;
        bit          hit_seen;
        int unsigned errors;
        int unsigned checked;
        int unsigned docs_closed;
        int unsigned docs_found;

        function new();
            query_low  = '0;
            query_high = '0;
            query_len  = '0;
            foreach (text_window[i]) text_window[i] = '0;
            window_fill = 0;
            in_tag      = 0;
            hit_seen    = 0;
            errors      = 0;
            checked     = 0;
            docs_closed = 0;
            docs_found  = 0;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_QUERY_LOW:  query_low  = value;
                CFG_QUERY_HIGH: query_high = value;
                CFG_QUERY_LEN:  query_len  = value[QUERY_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function char_t query_byte(int unsigned pos);
            if (pos < 8)
                return query_low[8*pos +: 8];
            if (pos < 16)
                return query_high[8*(pos-8) +: 8];
            return '0;
        endfunction

        function void shift_in(char_t c);
            for (int i = WINDOW_CHARS - 1; i > 0; i--)
                text_window[i] = text_window[i-1];
            text_window[0] = c;
            if (window_fill < WINDOW_CHARS)
                window_fill++;
        endfunction

        // One accepted byte: strip tags, fold case, slide the window, compare
        function void note_input(char_t raw, logic last);
            char_t    c;
            bit       added;
            bit       match;
            verdict_t owed;
            c     = raw;
            added = 0;
            if (c == CHAR_TAG_OPEN) begin
                in_tag = 1;
            end
            else if (c == CHAR_TAG_CLOSE) begin
                in_tag = 0;
                shift_in(CHAR_SPACE);
                added = 1;
            end
            else if (!in_tag) begin
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                    c = c + CASE_FOLD_OFS;
                shift_in(c);
                added = 1;
            end

            // newest window entry lines up with the last query character
            if (added && query_len != 0 && query_len <= WINDOW_CHARS
                    && window_fill >= query_len) begin
                match = 1;
                for (int i = 0; i < query_len; i++)
                    if (text_window[i] != query_byte(query_len - 1 - i))
                        match = 0;
                if (match)
                    hit_seen = 1;
            end

            owed.hit     = hit_seen;
            owed.closing = last;
            verdicts     = {verdicts, owed};

            if (last) begin
                docs_closed++;
                if (hit_seen)
                    docs_found++;
                foreach (text_window[i]) text_window[i] = '0;
                window_fill = 0;
                in_tag      = 0;
                hit_seen    = 0;
            end
        endfunction

        task report(string what);
            if (errors < PRINT_LIMIT)
                $display("%0t ns mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic got_found, logic got_final);
            verdict_t want;
            if (verdicts.size() == 0) begin
                report($sformatf("result with nothing owed (found=%b final=%b)",
                                 got_found, got_final));
                return;
            end
            want = verdicts.pop_front();
            checked++;
            if (got_found !== want.hit)
                report($sformatf("verdict %0d found=%b, want %b", checked, got_found, want.hit));
            if (got_final !== want.closing)
                report($sformatf("verdict %0d verdict_final=%b, want %b",
                                 checked, got_final, want.closing));
        endtask
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = CFG_QUERY_LOW;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    char_t                  data_byte     = '0;
    logic                   document_end  = 1'b0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic                   found;
    logic                   verdict_final;

    verdict_scoreboard sb = new();
    bit          steady        = 0;
    int unsigned items_sent    = 0;
    int unsigned setting_count = 0;
    int unsigned quiet_cycles  = 0;
    char_t       query_text[16];
    int          query_span    = 1;

    markup_stripping_substring_matcher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .document_end  (document_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .verdict_final (verdict_final)
    );

    always #5 clk = ~clk;

    // Result side: check each transfer, then pick next cycle's stall
    always @(posedge clk) begin
        if (out_valid && !out_stall)
            sb.check_result(found, verdict_final);
        out_stall <= !steady && ($urandom_range(99) < 21);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Small alphabet so partial and full matches happen often
    function automatic char_t text_char();
        if ($urandom_range(4) == 0)
            return CHAR_SPACE;
        return LOWER_A + char_t'($urandom_range(2));
    endfunction

    // Present one byte, with random idle cycles ahead of it, until it transfers
    task automatic send_byte(input char_t b, input logic last);
        while (!steady && $urandom_range(99) < 21) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        document_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(b, last);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close && (i == s.len() - 1));
    endtask

    // Hold the sender until every owed verdict is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write all three query registers back to back
    task automatic load_query(input logic [63:0] low_word, input logic [63:0] high_word,
                              input logic [4:0] len_value);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_QUERY_LOW;
        cfg_data  <= low_word;
        @(posedge clk);
        sb.write_reg(CFG_QUERY_LOW, low_word);
        cfg_index <= CFG_QUERY_HIGH;
        cfg_data  <= high_word;
        @(posedge clk);
        sb.write_reg(CFG_QUERY_HIGH, high_word);
        cfg_index <= CFG_QUERY_LEN;
        cfg_data  <= CFG_DATA_W'(len_value);
        @(posedge clk);
        sb.write_reg(CFG_QUERY_LEN, CFG_DATA_W'(len_value));
        cfg_we <= 1'b0;

        for (int i = 0; i < 8; i++) begin
            query_text[i]     = low_word[8*i +: 8];
            query_text[i + 8] = high_word[8*i +: 8];
        end
        if (len_value == 0)
            query_span = 4;
        else if (len_value > WINDOW_CHARS)
            query_span = WINDOW_CHARS;
        else
            query_span = len_value;
        setting_count++;
    endtask

    // Mostly well-formed text: query copies, tags, filler, with some raw noise
    task automatic send_document(input int budget, input bit close);
        int    stop;
        int    kind;
        int    cut;
        char_t c;
        stop = items_sent + budget;
        while (items_sent < stop) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                // full query, or a prefix of it, with case and boundary variants
                cut = (kind == 0) ? $urandom_range(query_span, 1) : query_span;
                for (int i = 0; i < cut; i++) begin
                    c = query_text[i];
                    if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(2) == 0)
                        c = c - CASE_FOLD_OFS;
                    else if (c == CHAR_SPACE && $urandom_range(2) == 0)
                        c = CHAR_TAG_CLOSE;
                    send_byte(c, 1'b0);
                end
            end
            else if (kind < 6) begin
                // tag with random body, sometimes left open
                send_byte(CHAR_TAG_OPEN, 1'b0);
                repeat ($urandom_range(4)) send_byte(char_t'($urandom_range(255)), 1'b0);
                if ($urandom_range(4) != 0)
                    send_byte(CHAR_TAG_CLOSE, 1'b0);
            end
            else if (kind < 9) begin
                repeat ($urandom_range(3, 1)) begin
                    c = text_char();
                    if (c != CHAR_SPACE && $urandom_range(1) == 0)
                        c = c - CASE_FOLD_OFS;
                    send_byte(c, 1'b0);
                end
            end
            else begin
                send_byte(char_t'($urandom_range(255)), 1'b0);
            end
        end
        if (close) begin
            case ($urandom_range(2))
                0:       c = query_text[query_span - 1];
                1:       c = text_char();
                default: c = char_t'($urandom_range(255));
            endcase
            send_byte(c, 1'b1);
        end
    endtask

    initial begin
        int          kind;
        int          n_docs;
        logic [63:0] low_word;
        logic [63:0] high_word;
        logic [4:0]  len_value;
        char_t       ch;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length never matches; extreme byte values
        load_query(64'd0, 64'd0, 5'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        // "hi": tag body dropped, close gives a space, upper case folds, flag stays set
        load_query(64'h6968, 64'd0, 5'd2);
        send_text("<p>Hi", 1'b0);
        send_text("<hi>", 1'b1);
        drain();

        // Full-length query of all-ones bytes, completed on the closing byte
        load_query('1, '1, 5'd16);
        repeat (15) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        // Random settings, each followed by a few documents
        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(9);
            for (int i = 0; i < 16; i++) begin
                ch = (kind == 3) ? char_t'($urandom_range(255)) : text_char();
                if (i < 8)
                    low_word[8*i +: 8] = ch;
                else
                    high_word[8*(i-8) +: 8] = ch;
            end
            case (kind)
                0:       len_value = 5'd0;
                1:       len_value = 5'd16;
                2:       len_value = 5'($urandom_range(31, 17));
                3:       len_value = 5'($urandom_range(16, 1));
                default: len_value = 5'($urandom_range(5, 1));
            endcase

            // one long phase runs with no idling on either side
            steady = (setting_count == 6);
            load_query(low_word, high_word, len_value);
            n_docs = $urandom_range(4, 1);
            for (int d = 0; d < n_docs; d++)
                send_document(steady ? 150 : $urandom_range(40, 4),
                              (d < n_docs - 1) || ($urandom_range(3) != 0));
            drain();
        end
        steady = 0;

        $display("Streamed %0d bytes through %0d query settings, %0d documents closed.",
                 items_sent, setting_count, sb.docs_closed);
        $display("Checked %0d verdicts; %0d documents ended with the query found.",
                 sb.checked, sb.docs_found);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
